// ===== hdl/cpu_alu_with_flags_top_macros.svh =====
// assertion macros for the alu with flags
`ifndef CPU_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define CALU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

`define CALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define CALU_ASSERT(lbl, clk, rst_n, prop)

`define CALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/calu_pkg.sv =====
// types and constants for the alu with flags
package calu_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_ADC   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SBC   = 5'd3,
		OP_AND   = 5'd4,
		OP_XOR   = 5'd5,
		OP_OR    = 5'd6,
		OP_CP    = 5'd7,
		OP_INC   = 5'd8,
		OP_DEC   = 5'd9,
		OP_DAA   = 5'd10,
		OP_CPL   = 5'd11,
		OP_SCF   = 5'd12,
		OP_CCF   = 5'd13,
		OP_RLCA  = 5'd14,
		OP_RRCA  = 5'd15,
		OP_RLA   = 5'd16,
		OP_RRA   = 5'd17,
		OP_RLC   = 5'd18,
		OP_RRC   = 5'd19,
		OP_RL    = 5'd20,
		OP_RR    = 5'd21,
		OP_SLA   = 5'd22,
		OP_SRA   = 5'd23,
		OP_SWAP  = 5'd24,
		OP_SRL   = 5'd25,
		OP_BIT   = 5'd26,
		OP_RES   = 5'd27,
		OP_SET   = 5'd28,
		OP_ADD16 = 5'd29,
		OP_ADDSP = 5'd30
	} calu_op_t;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	localparam logic [7:0] DAA_LIMIT    = 8'h99;
	localparam logic [3:0] DAA_NIB_MAX  = 4'd9;
	localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
	localparam logic [7:0] DAA_ADJ_HI   = 8'h60;

	typedef struct packed {
		logic [4:0]  mode;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic [2:0]  bit_index;
		logic [3:0]  flags_in;
	} calu_in_t;

	typedef struct packed {
		logic [15:0] result_value;
		logic [3:0]  flags_out;
	} calu_out_t;

endpackage

// ===== hdl/cpu_alu_with_flags_top.sv =====
// alu of an 8-bit cpu with z/n/h/c flags, registered in and out
// usage:
// - input channel in_valid/in_ready/in_item carries one operation item:
//   mode, operand_a, operand_b, bit_index and the incoming flags
// - output channel out_valid/out_ready/out_item returns one result item
//   per input item: result_value and flags_out, in input order
// - an accepted item is held in the input register, the whole operation is
//   evaluated combinationally from there and lands in the result register
// - out_valid rises when the item moves from input to result register
// - throughput: one item per cycle while out_ready stays high
// - in_ready is high when the input register is empty or moves on in the
//   same cycle; a stalled result holds and the input register then holds
//   one further item before in_ready falls
// - reset clears both valid flags; no item is lost or repeated across a
//   stall of any length
`include "cpu_alu_with_flags_top_macros.svh"

module cpu_alu_with_flags_top
	import calu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  calu_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output calu_out_t out_item
);

	logic      valid_s1;
	calu_in_t  item_s1;
	logic      out_valid_q;
	calu_out_t out_item_q;
	logic      adv_out;
	logic      adv_in;

	logic [7:0]  a;
	logic [7:0]  b;
	logic [15:0] a16;
	logic [15:0] b16;
	logic [3:0]  f;
	logic        cin;
	logic        nin;
	logic        hin;
	logic        t_add;
	logic        t_sub;
	logic [8:0]  sum_add;
	logic [4:0]  half_add;
	logic [8:0]  diff_sub;
	logic [4:0]  half_sub;
	logic [7:0]  inc_r;
	logic [7:0]  dec_r;
	logic        daa_lo;
	logic        daa_hi;
	logic [7:0]  daa_adj;
	logic [7:0]  daa_r;
	logic [7:0]  bit_mask;
	logic [16:0] sum16;
	logic [12:0] half16;
	logic [15:0] sp_r;
	logic [4:0]  sp_half;
	logic [8:0]  sp_carry;
	logic [7:0]  r8;
	logic        use8;
	logic [15:0] res;
	logic [3:0]  nf;

	assign adv_out  = !out_valid_q || out_ready;
	assign adv_in   = !valid_s1 || adv_out;
	assign in_ready = adv_in;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign a16 = item_s1.operand_a;
	assign b16 = item_s1.operand_b;
	assign a   = a16[7:0];
	assign b   = b16[7:0];
	assign f   = item_s1.flags_in;
	assign cin = f[FLAG_C];
	assign nin = f[FLAG_N];
	assign hin = f[FLAG_H];

	assign t_add    = (calu_op_t'(item_s1.mode) == OP_ADC) && cin;
	assign t_sub    = (calu_op_t'(item_s1.mode) == OP_SBC) && cin;
	assign sum_add  = {1'b0, a} + {1'b0, b} + {8'h00, t_add};
	assign half_add = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t_add};
	assign diff_sub = {1'b0, a} - {1'b0, b} - {8'h00, t_sub};
	assign half_sub = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t_sub};
	assign inc_r    = a + 8'h01;
	assign dec_r    = a - 8'h01;

	assign daa_lo  = hin || (!nin && (a[3:0] > DAA_NIB_MAX));
	assign daa_hi  = cin || (!nin && (a > DAA_LIMIT));
	assign daa_adj = (daa_lo ? DAA_ADJ_LO : 8'h00) | (daa_hi ? DAA_ADJ_HI : 8'h00);
	assign daa_r   = nin ? (a - daa_adj) : (a + daa_adj);

	assign bit_mask = 8'h01 << item_s1.bit_index;

	assign sum16    = {1'b0, a16} + {1'b0, b16};
	assign half16   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
	assign sp_r     = a16 + {{8{b[7]}}, b};
	assign sp_half  = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
	assign sp_carry = {1'b0, a16[7:0]} + {1'b0, b};

	always_comb begin
		r8   = 8'h00;
		use8 = 1'b1;
		res  = 16'h0000;
		nf   = f;
		unique case (item_s1.mode)
			OP_ADD, OP_ADC: begin
				r8 = sum_add[7:0];
				nf = {sum_add[7:0] == 8'h00, 1'b0, half_add[4], sum_add[8]};
			end
			OP_SUB, OP_SBC: begin
				r8 = diff_sub[7:0];
				nf = {diff_sub[7:0] == 8'h00, 1'b1, half_sub[4], diff_sub[8]};
			end
			OP_CP: begin
				use8 = 1'b0;
				res  = a16;
				nf   = {diff_sub[7:0] == 8'h00, 1'b1, half_sub[4], diff_sub[8]};
			end
			OP_AND: begin
				r8 = a & b;
				nf = {(a & b) == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			OP_XOR: begin
				r8 = a ^ b;
				nf = {(a ^ b) == 8'h00, 3'b000};
			end
			OP_OR: begin
				r8 = a | b;
				nf = {(a | b) == 8'h00, 3'b000};
			end
			OP_INC: begin
				r8 = inc_r;
				nf = {inc_r == 8'h00, 1'b0, inc_r[3:0] == 4'h0, cin};
			end
			OP_DEC: begin
				r8 = dec_r;
				nf = {dec_r == 8'h00, 1'b1, dec_r[3:0] == 4'hf, cin};
			end
			OP_DAA: begin
				r8 = daa_r;
				nf = {daa_r == 8'h00, nin, 1'b0, daa_hi};
			end
			OP_CPL: begin
				r8 = ~a;
				nf = {f[FLAG_Z], 1'b1, 1'b1, cin};
			end
			OP_SCF: begin
				r8 = a;
				nf = {f[FLAG_Z], 2'b00, 1'b1};
			end
			OP_CCF: begin
				r8 = a;
				nf = {f[FLAG_Z], 2'b00, !cin};
			end
			OP_RLCA: begin
				r8 = {a[6:0], a[7]};
				nf = {3'b000, a[7]};
			end
			OP_RRCA: begin
				r8 = {a[0], a[7:1]};
				nf = {3'b000, a[0]};
			end
			OP_RLA: begin
				r8 = {a[6:0], cin};
				nf = {3'b000, a[7]};
			end
			OP_RRA: begin
				r8 = {cin, a[7:1]};
				nf = {3'b000, a[0]};
			end
			OP_RLC: begin
				r8 = {a[6:0], a[7]};
				nf = {a == 8'h00, 2'b00, a[7]};
			end
			OP_RRC: begin
				r8 = {a[0], a[7:1]};
				nf = {a == 8'h00, 2'b00, a[0]};
			end
			OP_RL: begin
				r8 = {a[6:0], cin};
				nf = {{a[6:0], cin} == 8'h00, 2'b00, a[7]};
			end
			OP_RR: begin
				r8 = {cin, a[7:1]};
				nf = {{cin, a[7:1]} == 8'h00, 2'b00, a[0]};
			end
			OP_SLA: begin
				r8 = {a[6:0], 1'b0};
				nf = {a[6:0] == 7'h00, 2'b00, a[7]};
			end
			OP_SRA: begin
				r8 = {a[7], a[7:1]};
				nf = {a[7:1] == 7'h00 && !a[7], 2'b00, a[0]};
			end
			OP_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				nf = {a == 8'h00, 3'b000};
			end
			OP_SRL: begin
				r8 = {1'b0, a[7:1]};
				nf = {a[7:1] == 7'h00, 2'b00, a[0]};
			end
			OP_BIT: begin
				use8 = 1'b0;
				res  = a16;
				nf   = {!a[item_s1.bit_index], 1'b0, 1'b1, cin};
			end
			OP_RES: begin
				r8 = a & ~bit_mask;
			end
			OP_SET: begin
				r8 = a | bit_mask;
			end
			OP_ADD16: begin
				use8 = 1'b0;
				res  = sum16[15:0];
				nf   = {f[FLAG_Z], 1'b0, half16[12], sum16[16]};
			end
			OP_ADDSP: begin
				use8 = 1'b0;
				res  = sp_r;
				nf   = {2'b00, sp_half[4], sp_carry[8]};
			end
			default: begin
				use8 = 1'b0;
				res  = 16'h0000;
				nf   = f;
			end
		endcase
		if (use8) begin
			res = {8'h00, r8};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_in) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_in && in_valid) begin
			item_s1 <= in_item;
		end
		if (adv_out && valid_s1) begin
			out_item_q <= '{result_value: res, flags_out: nf};
		end
	end

	// a ready receiver never back-pressures the input side
	`CALU_ASSERT(a_ready_when_drained, clk, arst_n, out_ready |-> in_ready)
	// an item that leaves the input register appears at the output
	`CALU_ASSERT_NEXT(a_s1_to_out, clk, arst_n, valid_s1 && adv_out, out_valid)
	// an accepted item fills the input register
	`CALU_ASSERT_NEXT(a_in_to_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	// compare returns the first operand untouched
	`CALU_ASSERT_NEXT(a_cp_passes_a, clk, arst_n,
		valid_s1 && adv_out && (item_s1.mode == OP_CP),
		out_item.result_value == $past(item_s1.operand_a))

endmodule

// ===== test/tb_cpu_alu_with_flags_top.sv =====
// testbench for the alu with flags: directed and random operations checked against a predictor
`timescale 1ns / 100ps

module tb_cpu_alu_with_flags_top
	import calu_pkg::*;
();

	localparam logic [4:0] MODE_UNUSED = 5'd31;

	class alu_result_tracker;
		calu_out_t pending[$];
		int mismatches;
		int compared;
		int accepted;
		bit [31:0] codes_seen;

		function calu_out_t alu_compute(calu_in_t op);
			logic [7:0] a;
			logic [7:0] b;
			logic [7:0] r8;
			logic [15:0] r16;
			logic [3:0] fi;
			logic [3:0] fo;
			logic cin;
			logic cy;
			logic narrow;
			logic acc_rot;
			logic [8:0] sum9;
			logic [4:0] sum5;
			logic [12:0] sum13;
			logic [16:0] sum17;
			logic [7:0] adj;
			calu_out_t res;
			a = op.operand_a[7:0];
			b = op.operand_b[7:0];
			fi = op.flags_in;
			cin = fi[FLAG_C];
			fo = fi;
			r8 = 8'h00;
			r16 = 16'h0000;
			narrow = 1'b1;
			acc_rot = 1'b0;
			cy = 1'b0;
			case (op.mode)
				OP_ADD, OP_ADC: begin
					cy = (op.mode == OP_ADC) ? cin : 1'b0;
					sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
					sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
					r8 = sum9[7:0];
					fo = {r8 == 8'h00, 1'b0, sum5[4], sum9[8]};
				end
				OP_SUB, OP_SBC, OP_CP: begin
					cy = (op.mode == OP_SBC) ? cin : 1'b0;
					sum9 = {1'b0, a} - {1'b0, b} - {8'h00, cy};
					sum5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
					r8 = sum9[7:0];
					fo = {r8 == 8'h00, 1'b1, sum5[4], sum9[8]};
					if (op.mode == OP_CP) begin
						narrow = 1'b0;
						r16 = op.operand_a;
					end
				end
				OP_AND: begin
					r8 = a & b;
					fo = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
				end
				OP_XOR: begin
					r8 = a ^ b;
					fo = {r8 == 8'h00, 3'b000};
				end
				OP_OR: begin
					r8 = a | b;
					fo = {r8 == 8'h00, 3'b000};
				end
				OP_INC: begin
					r8 = a + 8'h01;
					fo = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cin};
				end
				OP_DEC: begin
					r8 = a - 8'h01;
					fo = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cin};
				end
				OP_DAA: begin
					adj = 8'h00;
					cy = cin;
					if (fi[FLAG_H] || (!fi[FLAG_N] && a[3:0] > DAA_NIB_MAX))
						adj = DAA_ADJ_LO;
					if (cin || (!fi[FLAG_N] && a > DAA_LIMIT)) begin
						adj = adj | DAA_ADJ_HI;
						cy = 1'b1;
					end
					r8 = fi[FLAG_N] ? a - adj : a + adj;
					fo = {r8 == 8'h00, fi[FLAG_N], 1'b0, cy};
				end
				OP_CPL: begin
					r8 = ~a;
					fo = {fi[FLAG_Z], 1'b1, 1'b1, cin};
				end
				OP_SCF: begin
					r8 = a;
					fo = {fi[FLAG_Z], 1'b0, 1'b0, 1'b1};
				end
				OP_CCF: begin
					r8 = a;
					fo = {fi[FLAG_Z], 1'b0, 1'b0, ~cin};
				end
				OP_RLCA, OP_RLC: begin
					r8 = {a[6:0], a[7]};
					cy = a[7];
					acc_rot = (op.mode == OP_RLCA);
					fo = {r8 == 8'h00 && !acc_rot, 2'b00, cy};
				end
				OP_RRCA, OP_RRC: begin
					r8 = {a[0], a[7:1]};
					cy = a[0];
					acc_rot = (op.mode == OP_RRCA);
					fo = {r8 == 8'h00 && !acc_rot, 2'b00, cy};
				end
				OP_RLA, OP_RL: begin
					r8 = {a[6:0], cin};
					cy = a[7];
					acc_rot = (op.mode == OP_RLA);
					fo = {r8 == 8'h00 && !acc_rot, 2'b00, cy};
				end
				OP_RRA, OP_RR: begin
					r8 = {cin, a[7:1]};
					cy = a[0];
					acc_rot = (op.mode == OP_RRA);
					fo = {r8 == 8'h00 && !acc_rot, 2'b00, cy};
				end
				OP_SLA: begin
					r8 = {a[6:0], 1'b0};
					fo = {r8 == 8'h00, 2'b00, a[7]};
				end
				OP_SRA: begin
					r8 = {a[7], a[7:1]};
					fo = {r8 == 8'h00, 2'b00, a[0]};
				end
				OP_SWAP: begin
					r8 = {a[3:0], a[7:4]};
					fo = {r8 == 8'h00, 3'b000};
				end
				OP_SRL: begin
					r8 = {1'b0, a[7:1]};
					fo = {r8 == 8'h00, 2'b00, a[0]};
				end
				OP_BIT: begin
					narrow = 1'b0;
					r16 = op.operand_a;
					fo = {~a[op.bit_index], 1'b0, 1'b1, cin};
				end
				OP_RES: r8 = a & ~(8'h01 << op.bit_index);
				OP_SET: r8 = a | (8'h01 << op.bit_index);
				OP_ADD16: begin
					narrow = 1'b0;
					sum17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
					sum13 = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
					r16 = sum17[15:0];
					fo = {fi[FLAG_Z], 1'b0, sum13[12], sum17[16]};
				end
				OP_ADDSP: begin
					narrow = 1'b0;
					r16 = op.operand_a + {{8{b[7]}}, b};
					sum5 = {1'b0, op.operand_a[3:0]} + {1'b0, b[3:0]};
					sum9 = {1'b0, op.operand_a[7:0]} + {1'b0, b};
					fo = {2'b00, sum5[4], sum9[8]};
				end
				default: begin
					r8 = 8'h00;
					fo = fi;
				end
			endcase
			res.result_value = narrow ? {8'h00, r8} : r16;
			res.flags_out = fo;
			return res;
		endfunction

		function void note_operation(calu_in_t op);
			accepted++;
			codes_seen[op.mode] = 1'b1;
			pending.push_back(alu_compute(op));
		endfunction

		function void check_result(calu_out_t got);
			calu_out_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result item, expected none, got value %h flags %b",
					$time, got.result_value, got.flags_out);
				mismatches++;
				return;
			end
			want = pending.pop_front();
			compared++;
			if (got.result_value !== want.result_value) begin
				$display("%0t: result_value mismatch, expected %h, got %h",
					$time, want.result_value, got.result_value);
				mismatches++;
			end
			if (got.flags_out !== want.flags_out) begin
				$display("%0t: flags_out mismatch, expected %b, got %b",
					$time, want.flags_out, got.flags_out);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	calu_in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	calu_out_t out_item;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	alu_result_tracker tracker = new();

	cpu_alu_with_flags_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_result(out_item);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic calu_in_t make_op(logic [4:0] mode, logic [15:0] a, logic [15:0] b,
		logic [2:0] bi, logic [3:0] f);
		calu_in_t op;
		op.mode = mode;
		op.operand_a = a;
		op.operand_b = b;
		op.bit_index = bi;
		op.flags_in = f;
		return op;
	endfunction

	function automatic logic [15:0] pick_operand();
		int sel;
		sel = $urandom_range(15);
		if (sel == 0)
			return 16'h0000;
		else if (sel == 1)
			return 16'hFFFF;
		else if (sel == 2)
			return {8'($urandom), 8'hFF};
		else if (sel == 3)
			return {8'($urandom), 8'h00};
		return 16'($urandom);
	endfunction

	function automatic calu_in_t random_op();
		calu_in_t op;
		op.mode = 5'($urandom_range(31));
		op.operand_a = pick_operand();
		op.operand_b = pick_operand();
		op.bit_index = 3'($urandom_range(7));
		op.flags_in = 4'($urandom_range(15));
		return op;
	endfunction

	task automatic send_op(calu_in_t op);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= op;
		do @(posedge clk); while (!in_ready);
		tracker.note_operation(op);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending.size() != 0);
	endtask

	task automatic run_random(int count);
		repeat (count) send_op(random_op());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every operation and the corner cases
		send_op(make_op(OP_ADD, 16'h00FF, 16'hFF01, 3'd0, 4'h0));
		send_op(make_op(OP_ADC, 16'hFF0F, 16'h0000, 3'd7, 4'h1));
		send_op(make_op(OP_SUB, 16'hAB10, 16'h5510, 3'd0, 4'hF));
		send_op(make_op(OP_SBC, 16'h0000, 16'h00FF, 3'd0, 4'h1));
		send_op(make_op(OP_AND, 16'hFFFF, 16'hFFFF, 3'd0, 4'h0));
		send_op(make_op(OP_XOR, 16'h12AA, 16'h34AA, 3'd0, 4'hF));
		send_op(make_op(OP_OR, 16'h0000, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_CP, 16'hFFFF, 16'h00FF, 3'd0, 4'h0));
		send_op(make_op(OP_INC, 16'h00FF, 16'h0000, 3'd0, 4'h1));
		send_op(make_op(OP_DEC, 16'h0000, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7));
		send_op(make_op(OP_DAA, 16'h0045, 16'h0000, 3'd0, 4'h1));
		send_op(make_op(OP_CPL, 16'h0055, 16'h0000, 3'd0, 4'hF));
		send_op(make_op(OP_SCF, 16'h00F0, 16'h0000, 3'd0, 4'hE));
		send_op(make_op(OP_CCF, 16'h000F, 16'h0000, 3'd0, 4'hF));
		send_op(make_op(OP_RLCA, 16'h0080, 16'h0000, 3'd0, 4'h8));
		send_op(make_op(OP_RRCA, 16'h0001, 16'h0000, 3'd0, 4'h8));
		send_op(make_op(OP_RLA, 16'h0080, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_RRA, 16'h0001, 16'h0000, 3'd0, 4'h1));
		send_op(make_op(OP_RLC, 16'h0000, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_RRC, 16'h0001, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_RL, 16'h0080, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_RR, 16'h0001, 16'h0000, 3'd0, 4'h1));
		send_op(make_op(OP_SLA, 16'h0080, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_SRA, 16'h0081, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_SWAP, 16'h00F0, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_SRL, 16'h0001, 16'h0000, 3'd0, 4'h0));
		send_op(make_op(OP_BIT, 16'hFFFE, 16'h0000, 3'd0, 4'h1));
		send_op(make_op(OP_RES, 16'h00FF, 16'h0000, 3'd7, 4'h0));
		send_op(make_op(OP_SET, 16'h0000, 16'h0000, 3'd0, 4'hF));
		send_op(make_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h8));
		send_op(make_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h0));
		send_op(make_op(OP_ADDSP, 16'hFFFF, 16'h0001, 3'd0, 4'hF));
		send_op(make_op(OP_ADDSP, 16'h0000, 16'hFF80, 3'd0, 4'h0));
		send_op(make_op(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'hA));
		drain_results();

		send_idle_pct = 35;
		recv_idle_pct = 47;
		run_random(200);
		drain_results();

		send_idle_pct = 47;
		recv_idle_pct = 35;
		run_random(200);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(200);
		in_valid <= 1'b0;

		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (tracker.pending.size() != 0)
			$display("%0d result items never arrived", tracker.pending.size());
		$display("sent %0d items using %0d of 32 mode codes, compared %0d results",
			tracker.accepted, $countones(tracker.codes_seen), tracker.compared);
		$display("three pacing phases plus a directed pass, %0d mismatches",
			tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
